### rtl/core/ifspf_pkg.sv
// Package: payload types, widths and register and mode codes of the I/Q mixer.
package ifspf_pkg;

    // Sample and result widths fixed by the payload structs.
    localparam int DATA_W     = 16;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 1;

    // Configuration port geometry.
    localparam int PERIOD_W   = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 2'd1;

    // Output mode codes; all other codes give zero.
    localparam logic [MODE_W-1:0] MODE_PASS       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHIFT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHIFT_FLIP = 3'd3;

    // One input request: the sample and the oscillator value.
    typedef struct packed {
        logic signed [DATA_W-1:0] in_i;
        logic signed [DATA_W-1:0] in_q;
        logic signed [DATA_W-1:0] ref_i;
        logic signed [DATA_W-1:0] ref_q;
    } in_t;

    // One result request.
    typedef struct packed {
        logic signed [OUT_W-1:0] out_i;
        logic signed [OUT_W-1:0] out_q;
    } out_t;

endpackage

### rtl/core/iq_freq_shift_phase_flip_modulator.sv
// Top level: complex mixer with a periodic sign flip, two register stages.
// A request passes through the input register and then the result register to the output.
// Throughput: one request per cycle, with the four 16x16 products, an add and a subtract
// between the input and result registers; a held result stalls the input once both are full.
// Reset (rst_n low, asynchronous) clears both valid flags, the sample counter, the sign
// flag and both configuration registers.
module iq_freq_shift_phase_flip_modulator #(
    parameter int COUNT_W = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ifspf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ifspf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ifspf_pkg::in_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ifspf_pkg::out_t                    out_data
);
    import ifspf_pkg::*;

    localparam int CMP_W = (COUNT_W > PERIOD_W) ? COUNT_W : PERIOD_W;

    logic [PERIOD_W-1:0]     flip_period_reg;
    logic [MODE_W-1:0]       output_mode_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic                    flag_reg;
    logic                    flag_next;

    logic                    s1_valid_reg;
    in_t                     s1_data_reg;
    logic                    s1_flag_reg;
    logic                    s2_valid_reg;
    out_t                    s2_data_reg;
    out_t                    s2_data_next;

    logic                    in_acc;
    logic                    en1;
    logic                    en2;
    logic                    period_hit;

    logic signed [PROD_W-1:0] p_iq;
    logic signed [PROD_W-1:0] p_qi;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_qq;
    logic signed [SUM_W-1:0]  shift_i;
    logic signed [SUM_W-1:0]  shift_q;
    logic signed [OUT_W-1:0]  pass_i;
    logic signed [OUT_W-1:0]  pass_q;
    logic signed [OUT_W-1:0]  mix_i;
    logic signed [OUT_W-1:0]  mix_q;

    // Pipeline advance: the result register frees when empty or being taken.
    assign en2      = !s2_valid_reg || !out_stall;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign in_acc   = in_valid && en1;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_period_reg <= '0;
            output_mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FLIP_PERIOD: flip_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_OUTPUT_MODE: output_mode_reg <= cfg_data[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sample counter and sign flag; the period is compared zero-extended.
    always_comb
    begin
        period_hit = (CMP_W'(count_reg) == CMP_W'(flip_period_reg));
        if (period_hit)
        begin
            count_next = '0;
            flag_next  = !flag_reg;
        end
        else
        begin
            count_next = count_reg + COUNT_W'(1);
            flag_next  = flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input register holds the sample and the flag as updated by this sample.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_data_reg <= in_data;
            s1_flag_reg <= flag_next;
        end
    end

    // Complex product and mode selection.
    always_comb
    begin
        p_iq    = s1_data_reg.in_i * s1_data_reg.ref_q;
        p_qi    = s1_data_reg.in_q * s1_data_reg.ref_i;
        p_ii    = s1_data_reg.in_i * s1_data_reg.ref_i;
        p_qq    = s1_data_reg.in_q * s1_data_reg.ref_q;
        shift_i = SUM_W'(p_iq) - SUM_W'(p_qi);
        shift_q = SUM_W'(p_ii) + SUM_W'(p_qq);
        pass_i  = OUT_W'(s1_data_reg.in_i);
        pass_q  = OUT_W'(s1_data_reg.in_q);
        mix_i   = OUT_W'(shift_i);
        mix_q   = OUT_W'(shift_q);

        case (output_mode_reg)
            MODE_PASS:
            begin
                s2_data_next.out_i = pass_i;
                s2_data_next.out_q = pass_q;
            end
            MODE_FLIP:
            begin
                s2_data_next.out_i = s1_flag_reg ? pass_i : ('0 - pass_i);
                s2_data_next.out_q = s1_flag_reg ? pass_q : ('0 - pass_q);
            end
            MODE_SHIFT:
            begin
                s2_data_next.out_i = mix_i;
                s2_data_next.out_q = mix_q;
            end
            MODE_SHIFT_FLIP:
            begin
                s2_data_next.out_i = s1_flag_reg ? mix_i : ('0 - mix_i);
                s2_data_next.out_q = s1_flag_reg ? mix_q : ('0 - mix_q);
            end
            default:
            begin
                s2_data_next.out_i = '0;
                s2_data_next.out_q = '0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

### rtl/core/ifspf_checker.sv
// Checker: port-level properties of the I/Q mixer and its bind statement.
module ifspf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  ifspf_pkg::out_t                    out_data
);
    import ifspf_pkg::*;

    // The input only stalls when a finished result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // An accepted request leads to a valid output after passing the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ##1 out_valid)
        else $error("accepted request did not reach the output");

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");

endmodule

bind iq_freq_shift_phase_flip_modulator ifspf_checker u_ifspf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
